[rtl/rlmm_pkg.sv]
// Shared types and codes for the resource lock and mailbox manager.
// Used by rlmm_eval and resource_lock_mailbox_manager; no dependencies.
package rlmm_pkg;

    localparam int OP_BITS = 2;
    localparam int PID_BITS = 3;
    localparam int ID_BITS = 4;
    localparam int MSG_BITS = 32;
    localparam int STATUS_BITS = 3;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS = 5;
    localparam int RES_COUNT_BITS = 5;
    localparam int MB_COUNT_BITS = 4;

    localparam logic [RES_COUNT_BITS-1:0] RES_COUNT_RESET = 5'd16;
    localparam logic [MB_COUNT_BITS-1:0] MB_COUNT_RESET = 4'd8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_RESOURCE_COUNT = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAILBOX_COUNT = 1'd1;

    // Operation codes.
    localparam logic [OP_BITS-1:0] OP_REQUEST = 2'd0;
    localparam logic [OP_BITS-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_SEND = 2'd2;
    localparam logic [OP_BITS-1:0] OP_RECEIVE = 2'd3;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] ST_ACQUIRED = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_NO_RESOURCE = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_WAITING = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_RELEASED = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_NOTHING_TO_RELEASE = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_SENT = 3'd5;
    localparam logic [STATUS_BITS-1:0] ST_RECEIVED = 3'd6;
    localparam logic [STATUS_BITS-1:0] ST_UNKNOWN_MAILBOX = 3'd7;

    typedef struct packed {
        logic [OP_BITS-1:0]  op;
        logic [PID_BITS-1:0] process_id;
        logic [ID_BITS-1:0]  resource_id;
        logic [MSG_BITS-1:0] message_in;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [MSG_BITS-1:0]    message_out;
        logic                   message_valid;
    } out_item_t;

    typedef struct packed {
        logic                free;
        logic [PID_BITS-1:0] holder;
    } res_entry_t;

    typedef struct packed {
        logic                full;
        logic [MSG_BITS-1:0] word;
    } mb_entry_t;

    localparam res_entry_t RES_ENTRY_RESET = '{free: 1'b1, holder: '0};
    localparam mb_entry_t MB_ENTRY_RESET = '{full: 1'b0, word: '0};

    // Decision for one operation: the result beat and the table write-backs.
    typedef struct packed {
        out_item_t  rsp;
        logic       res_we;
        res_entry_t res_wdata;
        logic       mb_we;
        mb_entry_t  mb_wdata;
    } eval_out_t;

endpackage

[rtl/resource_lock_mailbox_manager.sv]
// Top level of the resource lock and mailbox manager: sequencer, tables, result register.
// Depends on rlmm_pkg, rlmm_ram and rlmm_eval.
//
// Each operation is accepted in the idle state, and the resource and mailbox tables
// are read from their synchronous RAMs. In the execute state the result is decided;
// once the output register is empty or being emptied, the entry is written back and
// the result beat is loaded into the output register. A new operation is accepted
// in the cycle after that, even while the previous result is still waiting to be
// taken, but none is taken while an operation is in execution. The tables need no
// clearing pass after reset: per-entry valid bits make unwritten entries read as
// free resources and empty mailboxes.
module resource_lock_mailbox_manager #(
    parameter int MAX_RESOURCES = 16,
    parameter int MAX_MAILBOXES = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rlmm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rlmm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  rlmm_pkg::in_item_t                  req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output rlmm_pkg::out_item_t                 rsp
);
    import rlmm_pkg::*;

    localparam int RAW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int MAW = (MAX_MAILBOXES > 1) ? $clog2(MAX_MAILBOXES) : 1;
    localparam int RES_W = $bits(res_entry_t);
    localparam int MB_W = $bits(mb_entry_t);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                      state_reg, state_next;
    logic [RES_COUNT_BITS-1:0] res_count_reg;
    logic [MB_COUNT_BITS-1:0]  mb_count_reg;
    in_item_t                  item_reg;
    logic                      res_ok_reg, mb_ok_reg;
    logic [MAX_RESOURCES-1:0]  res_vld_reg;
    logic [MAX_MAILBOXES-1:0]  mb_vld_reg;
    logic                      rsp_valid_reg;
    out_item_t                 rsp_reg;

    logic                      accept;
    logic                      finish;
    logic                      res_ok_next, mb_ok_next;
    logic [RAW+ID_BITS-1:0]    req_res_wide, item_res_wide;
    logic [MAW+ID_BITS-1:0]    req_mb_wide, item_mb_wide;
    logic [RAW-1:0]            req_res_addr, item_res_addr;
    logic [MAW-1:0]            req_mb_addr, item_mb_addr;
    logic [RES_W-1:0]          res_rdata;
    logic [MB_W-1:0]           mb_rdata;
    res_entry_t                res_entry;
    mb_entry_t                 mb_entry;
    eval_out_t                 result;

    assign accept = req_valid && !req_stall;
    assign req_stall = (state_reg == S_EXEC);
    // The decision retires once the output register is empty or being emptied.
    assign finish = (state_reg == S_EXEC) && (!rsp_valid_reg || !rsp_stall);

    assign req_res_wide = {{RAW{1'b0}}, req.resource_id};
    assign req_mb_wide = {{MAW{1'b0}}, req.resource_id};
    assign item_res_wide = {{RAW{1'b0}}, item_reg.resource_id};
    assign item_mb_wide = {{MAW{1'b0}}, item_reg.resource_id};
    assign req_res_addr = req_res_wide[RAW-1:0];
    assign req_mb_addr = req_mb_wide[MAW-1:0];
    assign item_res_addr = item_res_wide[RAW-1:0];
    assign item_mb_addr = item_mb_wide[MAW-1:0];

    assign res_ok_next = ({1'b0, req.resource_id} < res_count_reg)
                         && (32'(req.resource_id) < 32'(MAX_RESOURCES));
    assign mb_ok_next = (req.resource_id < mb_count_reg)
                        && (32'(req.resource_id) < 32'(MAX_MAILBOXES));

    rlmm_ram #(
        .WIDTH(RES_W),
        .DEPTH(MAX_RESOURCES)
    ) u_res_ram (
        .clk  (clk),
        .we   (finish && result.res_we),
        .waddr(item_res_addr),
        .wdata(result.res_wdata),
        .re   (accept),
        .raddr(req_res_addr),
        .rdata(res_rdata)
    );

    rlmm_ram #(
        .WIDTH(MB_W),
        .DEPTH(MAX_MAILBOXES)
    ) u_mb_ram (
        .clk  (clk),
        .we   (finish && result.mb_we),
        .waddr(item_mb_addr),
        .wdata(result.mb_wdata),
        .re   (accept),
        .raddr(req_mb_addr),
        .rdata(mb_rdata)
    );

    // Entries never written since reset read as their reset contents.
    always_comb
    begin
        res_entry = RES_ENTRY_RESET;
        mb_entry = MB_ENTRY_RESET;
        if (res_ok_reg && res_vld_reg[item_res_addr])
        begin
            res_entry = res_rdata;
        end
        if (mb_ok_reg && mb_vld_reg[item_mb_addr])
        begin
            mb_entry = mb_rdata;
        end
    end

    rlmm_eval u_eval (
        .item     (item_reg),
        .res_ok   (res_ok_reg),
        .mb_ok    (mb_ok_reg),
        .res_entry(res_entry),
        .mb_entry (mb_entry),
        .result   (result)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_count_reg <= RES_COUNT_RESET;
            mb_count_reg <= MB_COUNT_RESET;
            res_vld_reg <= '0;
            mb_vld_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RESOURCE_COUNT: res_count_reg <= cfg_data;
                    REG_MAILBOX_COUNT:  mb_count_reg <= cfg_data[MB_COUNT_BITS-1:0];
                    default:            ;
                endcase
            end
            if (finish && result.res_we)
            begin
                res_vld_reg[item_res_addr] <= 1'b1;
            end
            if (finish && result.mb_we)
            begin
                mb_vld_reg[item_mb_addr] <= 1'b1;
            end
            if (finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
            res_ok_reg <= res_ok_next;
            mb_ok_reg <= mb_ok_next;
        end
        if (finish)
        begin
            rsp_reg <= result.rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

endmodule

[rtl/rlmm_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used for the resource and mailbox tables.
module rlmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/rlmm_eval.sv]
// Decision logic for one operation: from the fetched table entries it forms
// the result beat and the write-back data. Depends on rlmm_pkg.
module rlmm_eval (
    input  rlmm_pkg::in_item_t   item,
    input  logic                 res_ok,
    input  logic                 mb_ok,
    input  rlmm_pkg::res_entry_t res_entry,
    input  rlmm_pkg::mb_entry_t  mb_entry,
    output rlmm_pkg::eval_out_t  result
);
    import rlmm_pkg::*;

    always_comb
    begin
        result = '0;
        result.res_wdata = RES_ENTRY_RESET;
        result.mb_wdata = MB_ENTRY_RESET;
        case (item.op)
            OP_REQUEST:
            begin
                if (!res_ok)
                begin
                    result.rsp.status = ST_NO_RESOURCE;
                end
                else if (res_entry.free)
                begin
                    result.rsp.status = ST_ACQUIRED;
                    result.res_we = 1'b1;
                    result.res_wdata.free = 1'b0;
                    result.res_wdata.holder = item.process_id;
                end
                else
                begin
                    result.rsp.status = ST_WAITING;
                end
            end
            OP_RELEASE:
            begin
                if (res_ok && !res_entry.free && res_entry.holder == item.process_id)
                begin
                    result.rsp.status = ST_RELEASED;
                    result.res_we = 1'b1;
                end
                else
                begin
                    result.rsp.status = ST_NOTHING_TO_RELEASE;
                end
            end
            OP_SEND:
            begin
                if (!mb_ok)
                begin
                    result.rsp.status = ST_UNKNOWN_MAILBOX;
                end
                else
                begin
                    result.rsp.status = ST_SENT;
                    result.mb_we = 1'b1;
                    result.mb_wdata.full = 1'b1;
                    result.mb_wdata.word = item.message_in;
                end
            end
            default:
            begin
                if (!mb_ok)
                begin
                    result.rsp.status = ST_UNKNOWN_MAILBOX;
                end
                else
                begin
                    // Receiving empties the mailbox whether or not it was full.
                    result.rsp.status = ST_RECEIVED;
                    result.rsp.message_out = mb_entry.word;
                    result.rsp.message_valid = mb_entry.full;
                    result.mb_we = 1'b1;
                end
            end
        endcase
    end

endmodule

[verif/resource_lock_mailbox_manager_tb.sv]
// Self-checking testbench for resource_lock_mailbox_manager: directed table, then random phases.
// Depends on rlmm_pkg and the RTL of the block; results are checked against an in-bench predictor.
module resource_lock_mailbox_manager_tb;
    import rlmm_pkg::*;

    localparam int RESOURCES = 16;
    localparam int MAILBOXES = 8;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 200;
    localparam int IN_W = $bits(in_item_t);

    typedef enum logic {ROW_OP, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e                 kind;
        in_item_t                  beat;
        logic                      pinned;
        out_item_t                 result;
        logic [CFG_INDEX_BITS-1:0] cfg_sel;
        logic [CFG_DATA_BITS-1:0]  cfg_val;
    } row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      req_valid = 1'b0;
    logic                      req_stall;
    in_item_t                  req = '0;
    logic                      rsp_valid;
    logic                      rsp_stall = 1'b0;
    out_item_t                 rsp;

    // Expected result typed into the directed table, handed to the checker with the beat.
    logic      pin_on = 1'b0;
    out_item_t pin_result = '0;

    logic quiet = 1'b0;
    int   mismatches = 0;

    // Predictor state.
    logic                       res_free [RESOURCES];
    logic [PID_BITS-1:0]        res_owner [RESOURCES];
    logic [MSG_BITS-1:0]        mb_word [MAILBOXES];
    logic                       mb_full [MAILBOXES];
    logic [RES_COUNT_BITS-1:0]  res_limit;
    logic [MB_COUNT_BITS-1:0]   mb_limit;

    out_item_t pending_results [$];
    row_t      script [$];

    resource_lock_mailbox_manager u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    function automatic out_item_t lock_mailbox_predict(in_item_t beat);
        out_item_t           r;
        logic                res_ok;
        logic                mb_ok;
        logic [ID_BITS-1:0]  id;
        id = beat.resource_id;
        r = '0;
        res_ok = (id < res_limit) && (id < RESOURCES);
        mb_ok = (id < mb_limit) && (id < MAILBOXES);
        case (beat.op)
            OP_REQUEST:
            begin
                if (!res_ok)
                    r.status = ST_NO_RESOURCE;
                else if (res_free[id])
                begin
                    res_free[id] = 1'b0;
                    res_owner[id] = beat.process_id;
                    r.status = ST_ACQUIRED;
                end
                else
                    r.status = ST_WAITING;
            end
            OP_RELEASE:
            begin
                if (res_ok && !res_free[id] && res_owner[id] == beat.process_id)
                begin
                    res_free[id] = 1'b1;
                    res_owner[id] = '0;
                    r.status = ST_RELEASED;
                end
                else
                    r.status = ST_NOTHING_TO_RELEASE;
            end
            OP_SEND:
            begin
                if (!mb_ok)
                    r.status = ST_UNKNOWN_MAILBOX;
                else
                begin
                    mb_word[id] = beat.message_in;
                    mb_full[id] = 1'b1;
                    r.status = ST_SENT;
                end
            end
            default:
            begin
                if (!mb_ok)
                    r.status = ST_UNKNOWN_MAILBOX;
                else
                begin
                    r.message_out = mb_word[id];
                    r.message_valid = mb_full[id];
                    mb_word[id] = '0;
                    mb_full[id] = 1'b0;
                    r.status = ST_RECEIVED;
                end
            end
        endcase
        return r;
    endfunction

    function automatic row_t op_row(logic [OP_BITS-1:0] op, logic [PID_BITS-1:0] pid,
                                    logic [ID_BITS-1:0] id, logic [MSG_BITS-1:0] msg);
        row_t row;
        row = '{kind: ROW_OP, beat: '0, pinned: 1'b0, result: '0, cfg_sel: '0, cfg_val: '0};
        row.beat = '{op: op, process_id: pid, resource_id: id, message_in: msg};
        return row;
    endfunction

    function automatic row_t checked_row(logic [OP_BITS-1:0] op, logic [PID_BITS-1:0] pid,
                                         logic [ID_BITS-1:0] id, logic [MSG_BITS-1:0] msg,
                                         logic [STATUS_BITS-1:0] st,
                                         logic [MSG_BITS-1:0] mout, logic mvalid);
        row_t row;
        row = op_row(op, pid, id, msg);
        row.pinned = 1'b1;
        row.result = '{status: st, message_out: mout, message_valid: mvalid};
        return row;
    endfunction

    function automatic row_t cfg_row(logic [CFG_INDEX_BITS-1:0] sel,
                                     logic [CFG_DATA_BITS-1:0] val);
        row_t row;
        row = op_row(OP_REQUEST, '0, '0, '0);
        row.kind = ROW_CFG;
        row.cfg_sel = sel;
        row.cfg_val = val;
        return row;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Indexes lean toward the configured range and releases toward the holder,
    // so that acquire/release pairs and send/receive pairs actually happen.
    function automatic in_item_t random_op();
        in_item_t b;
        int       span;
        b.op = OP_BITS'($urandom_range(0, 3));
        b.process_id = PID_BITS'($urandom_range(0, 7));
        if (b.op == OP_REQUEST || b.op == OP_RELEASE)
            span = (res_limit < RESOURCES) ? res_limit : RESOURCES;
        else
            span = (mb_limit < MAILBOXES) ? mb_limit : MAILBOXES;
        if (span > 0 && $urandom_range(0, 9) < 8)
            b.resource_id = ID_BITS'($urandom_range(0, span - 1));
        else
            b.resource_id = ID_BITS'($urandom_range(0, 15));
        if (b.op == OP_RELEASE && $urandom_range(0, 2) != 0)
            b.process_id = res_owner[b.resource_id];
        case ($urandom_range(0, 9))
            0: b.message_in = '0;
            1: b.message_in = '1;
            default: b.message_in = $urandom;
        endcase
        return b;
    endfunction

    task automatic drive_op(input in_item_t beat, input logic pinned, input out_item_t result);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            req <= in_item_t'(IN_W'({$urandom, $urandom}));
            repeat (gap) @(negedge clk);
        end
        req <= beat;
        pin_on <= pinned;
        pin_result <= result;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Stop sending and wait until every expected result has been taken.
    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] sel,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Checker and predictor: the result beat is checked before the input beat of the
    // same edge is predicted, so the order of processes within a step does not matter.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result beat expected none, actual %h", $time, rsp);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp.status);
                        mismatches++;
                    end
                    if (rsp.message_out !== want.message_out)
                    begin
                        $display("%0t: message_out expected %h actual %h",
                                 $time, want.message_out, rsp.message_out);
                        mismatches++;
                    end
                    if (rsp.message_valid !== want.message_valid)
                    begin
                        $display("%0t: message_valid expected %b actual %b",
                                 $time, want.message_valid, rsp.message_valid);
                        mismatches++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                want = lock_mailbox_predict(req);
                if (pin_on)
                    want = pin_result;
                pending_results.push_back(want);
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_RESOURCE_COUNT)
                    res_limit = cfg_data;
                else
                    mb_limit = cfg_data[MB_COUNT_BITS-1:0];
            end
        end
    end

    // Receiver stalls: short and long runs, none at all while quiet.
    initial
    begin
        int len;
        forever
        begin
            @(negedge clk);
            if (quiet || $urandom_range(0, 2) != 0)
                rsp_stall <= 1'b0;
            else
            begin
                len = pick_gap();
                rsp_stall <= 1'b1;
                repeat (len) @(negedge clk);
            end
        end
    end

    initial
    begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [RES_COUNT_BITS-1:0] res_setting;
        logic [MB_COUNT_BITS-1:0]  mb_setting;
        in_item_t                  beat;
        for (int i = 0; i < RESOURCES; i++)
        begin
            res_free[i] = 1'b1;
            res_owner[i] = '0;
        end
        for (int i = 0; i < MAILBOXES; i++)
        begin
            mb_word[i] = '0;
            mb_full[i] = 1'b0;
        end
        res_limit = RES_COUNT_RESET;
        mb_limit = MB_COUNT_RESET;

        // Held resource: a second request waits, also from the holder itself.
        script.push_back(checked_row(OP_REQUEST, 3'd0, 4'd0, '0, ST_ACQUIRED, '0, 1'b0));
        script.push_back(checked_row(OP_REQUEST, 3'd3, 4'd0, '0, ST_WAITING, '0, 1'b0));
        script.push_back(checked_row(OP_REQUEST, 3'd0, 4'd0, '0, ST_WAITING, '0, 1'b0));
        script.push_back(checked_row(OP_RELEASE, 3'd3, 4'd0, '0, ST_NOTHING_TO_RELEASE, '0,
                                     1'b0));
        script.push_back(checked_row(OP_RELEASE, 3'd0, 4'd0, '0, ST_RELEASED, '0, 1'b0));
        script.push_back(checked_row(OP_RELEASE, 3'd0, 4'd0, '0, ST_NOTHING_TO_RELEASE, '0,
                                     1'b0));
        script.push_back(checked_row(OP_REQUEST, 3'd7, 4'd15, '1, ST_ACQUIRED, '0, 1'b0));
        script.push_back(checked_row(OP_RELEASE, 3'd7, 4'd15, '1, ST_RELEASED, '0, 1'b0));
        // Empty mailbox, overwrite of a full one, and the mailbox emptied by a receive.
        script.push_back(checked_row(OP_RECEIVE, 3'd0, 4'd0, '1, ST_RECEIVED, '0, 1'b0));
        script.push_back(checked_row(OP_SEND, 3'd1, 4'd0, '1, ST_SENT, '0, 1'b0));
        script.push_back(checked_row(OP_SEND, 3'd1, 4'd0, 32'hA5A5_5A5A, ST_SENT, '0, 1'b0));
        script.push_back(checked_row(OP_RECEIVE, 3'd2, 4'd0, '0, ST_RECEIVED, 32'hA5A5_5A5A,
                                     1'b1));
        script.push_back(checked_row(OP_SEND, 3'd6, 4'd7, '0, ST_SENT, '0, 1'b0));
        script.push_back(checked_row(OP_RECEIVE, 3'd6, 4'd7, '0, ST_RECEIVED, '0, 1'b1));
        script.push_back(checked_row(OP_SEND, 3'd0, 4'd8, '1, ST_UNKNOWN_MAILBOX, '0, 1'b0));
        script.push_back(checked_row(OP_RECEIVE, 3'd0, 4'd15, '1, ST_UNKNOWN_MAILBOX, '0,
                                     1'b0));
        script.push_back(op_row(OP_SEND, 3'd4, 4'd3, 32'h1234_5678));
        script.push_back(op_row(OP_REQUEST, 3'd5, 4'd9, 32'h8000_0001));
        // Shrunk tables: indexes past the count vanish, held state survives.
        script.push_back(cfg_row(REG_RESOURCE_COUNT, 5'd4));
        script.push_back(checked_row(OP_REQUEST, 3'd2, 4'd4, '0, ST_NO_RESOURCE, '0, 1'b0));
        script.push_back(checked_row(OP_REQUEST, 3'd2, 4'd3, '0, ST_ACQUIRED, '0, 1'b0));
        script.push_back(checked_row(OP_RELEASE, 3'd5, 4'd9, '0, ST_NOTHING_TO_RELEASE, '0,
                                     1'b0));
        script.push_back(cfg_row(REG_MAILBOX_COUNT, 5'd0));
        script.push_back(checked_row(OP_RECEIVE, 3'd4, 4'd3, '0, ST_UNKNOWN_MAILBOX, '0,
                                     1'b0));
        script.push_back(cfg_row(REG_RESOURCE_COUNT, 5'd0));
        script.push_back(checked_row(OP_REQUEST, 3'd0, 4'd0, '0, ST_NO_RESOURCE, '0, 1'b0));
        script.push_back(cfg_row(REG_RESOURCE_COUNT, 5'd16));
        script.push_back(cfg_row(REG_MAILBOX_COUNT, 5'd8));
        script.push_back(op_row(OP_RECEIVE, 3'd4, 4'd3, '0));
        script.push_back(op_row(OP_RELEASE, 3'd5, 4'd9, '0));

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(script[i].cfg_sel, script[i].cfg_val);
            end
            else
                drive_op(script[i].beat, script[i].pinned, script[i].result);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin res_setting = 5'd16; mb_setting = 4'd8; end
                1: begin res_setting = 5'd1;  mb_setting = 4'd1; end
                2: begin res_setting = 5'd0;  mb_setting = 4'd0; end
                3: begin res_setting = 5'd31; mb_setting = 4'd15; end
                4: begin res_setting = 5'd16; mb_setting = 4'd8; end
                5: begin res_setting = 5'd3;  mb_setting = 4'd2; end
                default:
                begin
                    res_setting = RES_COUNT_BITS'($urandom_range(1, 16));
                    mb_setting = MB_COUNT_BITS'($urandom_range(1, 8));
                end
            endcase
            settle();
            quiet = (p == 4);
            write_reg(REG_RESOURCE_COUNT, res_setting);
            write_reg(REG_MAILBOX_COUNT, {1'b0, mb_setting});
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Hold off the sender once mid-phase until the block has drained.
                if (p == 6 && n == PHASE_ITEMS / 2)
                    settle();
                beat = random_op();
                drive_op(beat, 1'b0, '0);
            end
        end
        quiet = 1'b0;

        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
rtl/rlmm_pkg.sv
rtl/rlmm_ram.sv
rtl/rlmm_eval.sv
rtl/resource_lock_mailbox_manager.sv
verif/resource_lock_mailbox_manager_tb.sv
